// File: src/abqrc_pkg.sv
// Shared types and codes for the audio buffer queue rate controller.
// Depends on nothing; used by every module of the block.
package abqrc_pkg;

   localparam int unsigned CFG_W  = 5;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned SLOT_W = 4;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_RATE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CAPACITY = 3'd1;
   localparam logic [KIND_W-1:0] KIND_COMMIT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DMA      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESTART  = 3'd4;

   // rate codes
   localparam logic [2:0] RATE_NEUTRAL   = 3'd0;
   localparam logic [2:0] RATE_SLOW      = 3'd1;
   localparam logic [2:0] RATE_SLOW_EMRG = 3'd2;
   localparam logic [2:0] RATE_FAST      = 3'd3;
   localparam logic [2:0] RATE_FAST_EMRG = 3'd4;

   // playback actions
   localparam logic [1:0] ACT_NONE     = 2'd0;
   localparam logic [1:0] ACT_PLAY     = 2'd1;
   localparam logic [1:0] ACT_FADE_OUT = 2'd2;
   localparam logic [1:0] ACT_STOP     = 2'd3;

   // register indexes
   localparam logic [7:0] REG_HIGH_WATER    = 8'd0;
   localparam logic [7:0] REG_HIGH_RELEASE  = 8'd1;
   localparam logic [7:0] REG_LOW_RELEASE   = 8'd2;
   localparam logic [7:0] REG_LOW_WATER     = 8'd3;
   localparam logic [7:0] REG_LOW_CRITICAL  = 8'd4;
   localparam logic [7:0] REG_HIGH_CRITICAL = 8'd5;
   localparam logic [7:0] REG_START_LEVEL   = 8'd6;
   localparam logic [7:0] REG_MAX_QUEUED    = 8'd7;

   typedef struct packed {
      logic [CFG_W-1:0] high_water;
      logic [CFG_W-1:0] high_release;
      logic [CFG_W-1:0] low_release;
      logic [CFG_W-1:0] low_water;
      logic [CFG_W-1:0] low_critical;
      logic [CFG_W-1:0] high_critical;
      logic [CFG_W-1:0] start_level;
      logic [CFG_W-1:0] max_queued;
   } cfg_type;

   typedef struct packed {
      logic              fire;
      logic [KIND_W-1:0] kind;
      logic              hold;
   } event_type;

   typedef struct packed {
      logic [SLOT_W-1:0] write_slot;
      logic [SLOT_W-1:0] unplayed;
      logic              start_dma;
      logic              fade_in;
      logic              build_fade_out;
      logic [SLOT_W-1:0] play_slot;
      logic [1:0]        action;
      logic              can_write;
      logic [2:0]        rate_code;
   } result_type;

endpackage

// File: src/abqrc_csr.sv
// Configuration register file of the rate controller.
// Depends on abqrc_pkg for the register indexes and the cfg_type struct.
module abqrc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [7:0]                     wr_index,
   input  logic [abqrc_pkg::CFG_W-1:0]    wr_data,
   output abqrc_pkg::cfg_type             cfg
);

   abqrc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_water    <= 5'd8;
         cfg_ff.high_release  <= 5'd6;
         cfg_ff.low_release   <= 5'd6;
         cfg_ff.low_water     <= 5'd4;
         cfg_ff.low_critical  <= 5'd1;
         cfg_ff.high_critical <= 5'd11;
         cfg_ff.start_level   <= 5'd6;
         cfg_ff.max_queued    <= 5'd12;
      end else if (wr_en) begin
         case (wr_index)
            abqrc_pkg::REG_HIGH_WATER:    cfg_ff.high_water    <= wr_data;
            abqrc_pkg::REG_HIGH_RELEASE:  cfg_ff.high_release  <= wr_data;
            abqrc_pkg::REG_LOW_RELEASE:   cfg_ff.low_release   <= wr_data;
            abqrc_pkg::REG_LOW_WATER:     cfg_ff.low_water     <= wr_data;
            abqrc_pkg::REG_LOW_CRITICAL:  cfg_ff.low_critical  <= wr_data;
            abqrc_pkg::REG_HIGH_CRITICAL: cfg_ff.high_critical <= wr_data;
            abqrc_pkg::REG_START_LEVEL:   cfg_ff.start_level   <= wr_data;
            abqrc_pkg::REG_MAX_QUEUED:    cfg_ff.max_queued    <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/abqrc_ctrl.sv
// Ring state and event decode of the rate controller.
// Depends on abqrc_pkg for event codes and the cfg, event and result structs.
module abqrc_ctrl #(
   parameter int unsigned RING_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  abqrc_pkg::event_type  ev,
   input  abqrc_pkg::cfg_type    cfg,
   output abqrc_pkg::result_type res
);

   localparam int unsigned IDX_W = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;
   localparam int unsigned CMP_W = (IDX_W > abqrc_pkg::CFG_W) ? IDX_W : abqrc_pkg::CFG_W;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_SLOTS - 1);
   localparam logic [IDX_W:0]   RING_EXT  = (IDX_W+1)'(RING_SLOTS);

   typedef enum logic [1:0] {
      RS_NEUTRAL  = 2'd0,
      RS_DRAINING = 2'd1,
      RS_FILLING  = 2'd2
   } rate_state_type;

   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [IDX_W-1:0] play_index_ff, play_index_in;
   logic             started_ff, started_in;
   logic             starved_ff, starved_in;
   rate_state_type   rate_state_ff, rate_state_in;

   logic [IDX_W-1:0] write_adv, play_adv;
   logic [CMP_W-1:0] q_now, q_commit, q_after;
   logic [CMP_W-1:0] c_hw, c_hr, c_lr, c_lw, c_lc, c_hc, c_sl, c_mq;

   // unplayed count, wrapping modulo the ring size
   function automatic logic [CMP_W-1:0] queued(input logic [IDX_W-1:0] w,
                                               input logic [IDX_W-1:0] p);
      logic [IDX_W:0] d;
      d = (w >= p) ? ({1'b0, w} - {1'b0, p}) : ({1'b0, w} + RING_EXT - {1'b0, p});
      return CMP_W'(d[IDX_W-1:0]);
   endfunction

   assign write_adv = (write_index_ff == LAST_SLOT) ? '0 : write_index_ff + 1'b1;
   assign play_adv  = (play_index_ff == LAST_SLOT) ? '0 : play_index_ff + 1'b1;
   assign q_now     = queued(write_index_ff, play_index_ff);
   assign q_commit  = queued(write_adv, play_index_ff);

   assign c_hw = CMP_W'(cfg.high_water);
   assign c_hr = CMP_W'(cfg.high_release);
   assign c_lr = CMP_W'(cfg.low_release);
   assign c_lw = CMP_W'(cfg.low_water);
   assign c_lc = CMP_W'(cfg.low_critical);
   assign c_hc = CMP_W'(cfg.high_critical);
   assign c_sl = CMP_W'(cfg.start_level);
   assign c_mq = CMP_W'(cfg.max_queued);

   always_comb begin
      rate_state_type rs;
      write_index_in = write_index_ff;
      play_index_in  = play_index_ff;
      started_in     = started_ff;
      starved_in     = starved_ff;
      rate_state_in  = rate_state_ff;
      rs             = rate_state_ff;
      res            = '0;

      case (ev.kind)
         abqrc_pkg::KIND_RATE: begin
            if (rs == RS_DRAINING && q_now <= c_hr) begin
               rs = RS_NEUTRAL;
            end else if (rs == RS_FILLING && q_now >= c_lr) begin
               rs = RS_NEUTRAL;
            end
            if (q_now > c_hw) begin
               rs = RS_DRAINING;
            end else if (q_now < c_lw) begin
               rs = RS_FILLING;
            end
            rate_state_in = rs;
            if (rs == RS_DRAINING) begin
               res.rate_code = (q_now >= c_hc) ? abqrc_pkg::RATE_SLOW_EMRG
                                               : abqrc_pkg::RATE_SLOW;
            end else if (rs == RS_FILLING) begin
               res.rate_code = (q_now <= c_lc) ? abqrc_pkg::RATE_FAST_EMRG
                                               : abqrc_pkg::RATE_FAST;
            end
         end
         abqrc_pkg::KIND_CAPACITY: begin
            if (ev.hold) begin
               // pause: stop DMA and drop the whole ring
               res.action     = abqrc_pkg::ACT_STOP;
               write_index_in = '0;
               play_index_in  = '0;
               started_in     = 1'b0;
               starved_in     = 1'b0;
               rate_state_in  = RS_NEUTRAL;
            end else begin
               res.can_write = (q_now < c_mq);
            end
         end
         abqrc_pkg::KIND_COMMIT: begin
            write_index_in = write_adv;
            if (!started_ff && q_commit >= c_sl) begin
               res.action    = abqrc_pkg::ACT_PLAY;
               res.play_slot = abqrc_pkg::SLOT_W'(CMP_W'(play_index_ff));
               res.start_dma = 1'b1;
               play_index_in = play_adv;
               started_in    = 1'b1;
            end
         end
         abqrc_pkg::KIND_DMA: begin
            if (!ev.hold) begin
               if (q_now == '0) begin
                  res.action         = abqrc_pkg::ACT_FADE_OUT;
                  res.build_fade_out = !starved_ff;
                  starved_in         = 1'b1;
               end else begin
                  res.action    = abqrc_pkg::ACT_PLAY;
                  res.play_slot = abqrc_pkg::SLOT_W'(CMP_W'(play_index_ff));
                  res.fade_in   = starved_ff;
                  starved_in    = 1'b0;
                  play_index_in = play_adv;
               end
            end
         end
         abqrc_pkg::KIND_RESTART: begin
            write_index_in = '0;
            play_index_in  = '0;
            started_in     = 1'b0;
            starved_in     = 1'b0;
            rate_state_in  = RS_NEUTRAL;
         end
         default: ;
      endcase

      q_after        = queued(write_index_in, play_index_in);
      res.unplayed   = q_after[abqrc_pkg::SLOT_W-1:0];
      res.write_slot = abqrc_pkg::SLOT_W'(CMP_W'(write_index_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         play_index_ff  <= '0;
         started_ff     <= 1'b0;
         starved_ff     <= 1'b0;
         rate_state_ff  <= RS_NEUTRAL;
      end else if (ev.fire) begin
         write_index_ff <= write_index_in;
         play_index_ff  <= play_index_in;
         started_ff     <= started_in;
         starved_ff     <= starved_in;
         rate_state_ff  <= rate_state_in;
      end
   end

endmodule

// File: src/audio_buffer_queue_rate_control_top.sv
// Audio buffer ring controller with hysteresis rate control: top level.
// Depends on abqrc_pkg, abqrc_csr and abqrc_ctrl.
//
// Usage:
//   The req_ stream carries one event per request: req_tuser holds the event
//   kind (rate query, capacity query, commit, DMA request, restart) and
//   req_tdata bit 0 holds the hold flag. Every request yields exactly one
//   response on the rsp_ stream with the rate code, the playback action, the
//   slot to play, fade flags, start_dma, and the unplayed count and write
//   slot after the event.
//   The csr_ port writes one of eight 5-bit thresholds per cycle; csr_ready
//   is high whenever reset is low. Write it only while no request is in flight.
//
// Timing:
//   A request lands in an input register, is decoded against the ring state
//   and the thresholds, and leaves through the response register: rsp_tvalid
//   rises once the request has moved from the input register into the
//   response register. One request per cycle is sustained while rsp_tready
//   stays high; the ring state register updates as each request moves into
//   the response register, so back-to-back events chain.
//   When rsp_tready is low the response holds and the input register fills;
//   req_tready drops only when both are occupied.
//   Reset (synchronous, active high) empties both registers, restores the
//   threshold defaults and clears the indices, started, starved and the
//   rate state; req_tready and csr_ready stay low while it is asserted.
module audio_buffer_queue_rate_control_top #(
   parameter int unsigned RING_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] hold, [7:1] zero
   input  logic [2:0]  req_tuser,   // [2:0] kind
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] rate_code, [3] can_write, [5:4] action, [9:6] play_slot,
   // [10] build_fade_out, [11] fade_in, [12] start_dma, [16:13] unplayed,
   // [20:17] write_slot, [23:21] zero
   output logic [23:0] rsp_tdata,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   logic                                in_valid_ff;
   logic [abqrc_pkg::KIND_W-1:0]        in_kind_ff;
   logic                                in_hold_ff;
   logic                                out_valid_ff;
   abqrc_pkg::result_type               out_data_ff;
   logic                                advance;
   abqrc_pkg::event_type                ev;
   abqrc_pkg::cfg_type                  cfg;
   abqrc_pkg::result_type               res;

   assign csr_ready = !reset;

   abqrc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // move the held request into the response register when there is room
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || advance);

   assign ev.fire = advance;
   assign ev.kind = in_kind_ff;
   assign ev.hold = in_hold_ff;

   abqrc_ctrl #(
      .RING_SLOTS (RING_SLOTS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .ev    (ev),
      .cfg   (cfg),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_hold_ff <= req_tdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_data_ff};

   // a request never enters while both registers are full and stalled
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipeline stalled");

   // starting the DMA always plays a queued slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.start_dma) |-> (out_data_ff.action == abqrc_pkg::ACT_PLAY))
      else $error("start_dma without a queued play");

   // a rate code only comes with no playback action and no capacity answer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.rate_code != abqrc_pkg::RATE_NEUTRAL)
         |-> (out_data_ff.action == abqrc_pkg::ACT_NONE && !out_data_ff.can_write))
      else $error("rate code mixed with another answer");

   // a fade-out rebuild never comes with a queued play
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.build_fade_out)
         |-> (out_data_ff.action == abqrc_pkg::ACT_FADE_OUT))
      else $error("fade-out rebuild outside a fade-out play");

endmodule

// File: tb/audio_buffer_queue_rate_control_top_tb.sv
// Self-checking testbench for audio_buffer_queue_rate_control_top: random request and
// response stalls, a ring predictor with a scoreboard class, threshold sweeps over the csr_ port.
// Depends on abqrc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module audio_buffer_queue_rate_control_top_tb;

   localparam int unsigned RING_SLOTS      = 16;
   localparam int unsigned HOLD_OFF_CYCLES = 80;    // long receiver hold-off
   localparam int unsigned STALL_LIMIT     = 1000;  // cycles with no handshake at all
   localparam int unsigned SETTLE_CYCLES   = 4;     // two-stage pipe plus margin
   localparam int unsigned PHASE_ITEMS     = 105;

   // threshold sets used by the sweep
   localparam abqrc_pkg::cfg_type RESET_LIMITS = '{high_water: 5'd8, high_release: 5'd6,
                                        low_release: 5'd6, low_water: 5'd4,
                                        low_critical: 5'd1, high_critical: 5'd11,
                                        start_level: 5'd6, max_queued: 5'd12};
   localparam abqrc_pkg::cfg_type WIDE_LIMITS  = '{high_water: 5'd12, high_release: 5'd3,
                                        low_release: 5'd9, low_water: 5'd5,
                                        low_critical: 5'd2, high_critical: 5'd14,
                                        start_level: 5'd2, max_queued: 5'd15};

   // hysteresis state of the pitch-bend control
   typedef enum logic [1:0] {
      FLOW_NEUTRAL  = 2'd0,
      FLOW_DRAINING = 2'd1,
      FLOW_FILLING  = 2'd2
   } flow_state_type;

   // Ring predictor and response checker. Every accepted request yields one
   // predicted response; responses are matched in order.
   class playback_scoreboard;
      abqrc_pkg::cfg_type           limits;
      logic [abqrc_pkg::SLOT_W-1:0] write_ptr;
      logic [abqrc_pkg::SLOT_W-1:0] play_ptr;
      bit                           running;
      bit                           starved;
      flow_state_type               flow;
      abqrc_pkg::result_type        due_results[$];
      int unsigned                  mismatches;

      function new();
         limits     = RESET_LIMITS;
         mismatches = 0;
         empty_ring();
      endfunction

      function void empty_ring();
         write_ptr = '0;
         play_ptr  = '0;
         running   = 1'b0;
         starved   = 1'b0;
         flow      = FLOW_NEUTRAL;
      endfunction

      function logic [abqrc_pkg::SLOT_W-1:0] step_slot(logic [abqrc_pkg::SLOT_W-1:0] slot);
         return (int'(slot) + 1 >= RING_SLOTS) ? '0 : slot + 1'b1;
      endfunction

      // buffers queued but not yet handed to the DMA
      function int unsigned backlog();
         return (int'(write_ptr) + RING_SLOTS - int'(play_ptr)) % RING_SLOTS;
      endfunction

      function void set_register(logic [7:0] idx, logic [abqrc_pkg::CFG_W-1:0] val);
         case (idx)
            abqrc_pkg::REG_HIGH_WATER:    limits.high_water    = val;
            abqrc_pkg::REG_HIGH_RELEASE:  limits.high_release  = val;
            abqrc_pkg::REG_LOW_RELEASE:   limits.low_release   = val;
            abqrc_pkg::REG_LOW_WATER:     limits.low_water     = val;
            abqrc_pkg::REG_LOW_CRITICAL:  limits.low_critical  = val;
            abqrc_pkg::REG_HIGH_CRITICAL: limits.high_critical = val;
            abqrc_pkg::REG_START_LEVEL:   limits.start_level   = val;
            abqrc_pkg::REG_MAX_QUEUED:    limits.max_queued    = val;
            default: ;
         endcase
      endfunction

      function void note_event(logic [abqrc_pkg::KIND_W-1:0] kind, logic hold);
         abqrc_pkg::result_type r;
         int unsigned           u;
         r = '0;
         case (kind)
            abqrc_pkg::KIND_RATE: begin
               u = backlog();
               // release first, then the water marks may override
               if (flow == FLOW_DRAINING && u <= limits.high_release)
                  flow = FLOW_NEUTRAL;
               else if (flow == FLOW_FILLING && u >= limits.low_release)
                  flow = FLOW_NEUTRAL;
               if (u > limits.high_water)
                  flow = FLOW_DRAINING;
               else if (u < limits.low_water)
                  flow = FLOW_FILLING;
               if (flow == FLOW_DRAINING)
                  r.rate_code = (u >= limits.high_critical) ? abqrc_pkg::RATE_SLOW_EMRG
                                                            : abqrc_pkg::RATE_SLOW;
               else if (flow == FLOW_FILLING)
                  r.rate_code = (u <= limits.low_critical) ? abqrc_pkg::RATE_FAST_EMRG
                                                           : abqrc_pkg::RATE_FAST;
            end
            abqrc_pkg::KIND_CAPACITY: begin
               if (hold) begin
                  r.action = abqrc_pkg::ACT_STOP;
                  empty_ring();
               end else begin
                  r.can_write = (backlog() < limits.max_queued);
               end
            end
            abqrc_pkg::KIND_COMMIT: begin
               // hold plays no part here; an overfull ring simply wraps
               write_ptr = step_slot(write_ptr);
               if (!running && backlog() >= limits.start_level) begin
                  r.action    = abqrc_pkg::ACT_PLAY;
                  r.play_slot = play_ptr;
                  r.start_dma = 1'b1;
                  play_ptr    = step_slot(play_ptr);
                  running     = 1'b1;
               end
            end
            abqrc_pkg::KIND_DMA: begin
               if (!hold) begin
                  if (backlog() == 0) begin
                     if (!starved) begin
                        r.build_fade_out = 1'b1;
                        starved          = 1'b1;
                     end
                     r.action = abqrc_pkg::ACT_FADE_OUT;
                  end else begin
                     r.play_slot = play_ptr;
                     if (starved) begin
                        r.fade_in = 1'b1;
                        starved   = 1'b0;
                     end
                     r.action = abqrc_pkg::ACT_PLAY;
                     play_ptr = step_slot(play_ptr);
                  end
               end
            end
            abqrc_pkg::KIND_RESTART: empty_ring();
            default: ;
         endcase
         r.unplayed   = abqrc_pkg::SLOT_W'(backlog());
         r.write_slot = write_ptr;
         due_results.push_back(r);
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         mismatches++;
         $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      endtask

      task compare_field(string what, int unsigned got, int unsigned want);
         if (got != want)
            report(what, got, want);
      endtask

      task check_result(logic [23:0] data);
         abqrc_pkg::result_type got;
         abqrc_pkg::result_type want;
         got = data[20:0];
         if (due_results.size() == 0) begin
            report("unrequested response tdata", 32'(data), 0);
            return;
         end
         want = due_results.pop_front();
         compare_field("rate_code", got.rate_code, want.rate_code);
         compare_field("can_write", got.can_write, want.can_write);
         compare_field("action", got.action, want.action);
         compare_field("play_slot", got.play_slot, want.play_slot);
         compare_field("build_fade_out", got.build_fade_out, want.build_fade_out);
         compare_field("fade_in", got.fade_in, want.fade_in);
         compare_field("start_dma", got.start_dma, want.start_dma);
         compare_field("unplayed", got.unplayed, want.unplayed);
         compare_field("write_slot", got.write_slot, want.write_slot);
         compare_field("tdata padding", data[23:21], 0);
      endtask
   endclass

   // every input known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [0] hold, [7:1] zero
   logic [2:0]  req_tuser  = '0;   // [2:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [2:0] rate_code, [3] can_write, [5:4] action, [9:6] play_slot,
   // [10] build_fade_out, [11] fade_in, [12] start_dma, [16:13] unplayed,
   // [20:17] write_slot, [23:21] zero
   logic [23:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index  = '0;
   logic [4:0]  csr_wdata  = '0;

   // idling controls shared by the sender, the receiver and the sequencer
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;
   bit squeeze_req     = 1'b0;

   playback_scoreboard board;

   audio_buffer_queue_rate_control_top #(.RING_SLOTS(RING_SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Sample both handshakes at the rising edge. Check the response before
   // noting the request so a stray response cannot hide behind a new entry.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            board.note_event(req_tuser, req_tdata[0]);
      end
   end

   // Receiver: drive rsp_tready at the falling edge. Random stalls, a steady
   // mode, and one long hold-off counted here so the block backs up into
   // its input and drops req_tready.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (squeeze_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            squeeze_req = 1'b0;
         end
         if (receiver_steady) begin
            rsp_tready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   // Watchdog: abort when no handshake of any kind happens for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Offer one request after an optional gap and hold it until accepted.
   // Leave valid high on return so the next request can follow back to back.
   task send_request(logic [abqrc_pkg::KIND_W-1:0] kind, logic hold);
      int unsigned gap;
      gap = sender_steady ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {7'd0, hold};
      do @(posedge clock); while (!req_tready);
   endtask

   task drop_valid();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task write_register(logic [7:0] idx, logic [abqrc_pkg::CFG_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Wait out every outstanding response, then let the pipe settle.
   task wait_for_results();
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all eight thresholds, plus one write to an unmapped index that
   // the block must drop.
   task apply_settings(abqrc_pkg::cfg_type s);
      write_register(abqrc_pkg::REG_HIGH_WATER, s.high_water);
      write_register(abqrc_pkg::REG_HIGH_RELEASE, s.high_release);
      write_register(abqrc_pkg::REG_LOW_RELEASE, s.low_release);
      write_register(abqrc_pkg::REG_LOW_WATER, s.low_water);
      write_register(abqrc_pkg::REG_LOW_CRITICAL, s.low_critical);
      write_register(abqrc_pkg::REG_HIGH_CRITICAL, s.high_critical);
      write_register(abqrc_pkg::REG_START_LEVEL, s.start_level);
      write_register(abqrc_pkg::REG_MAX_QUEUED, s.max_queued);
      write_register(abqrc_pkg::REG_MAX_QUEUED + 8'($urandom_range(1, 248)),
                     5'($urandom_range(0, 31)));
   endtask

   // Walk the corner events under the reset thresholds.
   task run_directed();
      send_request(abqrc_pkg::KIND_RATE, 1'b0);       // empty ring: emergency fast
      send_request(abqrc_pkg::KIND_DMA, 1'b0);        // before start, empty: build fade-out
      send_request(abqrc_pkg::KIND_DMA, 1'b0);        // still starved: fade-out, no rebuild
      send_request(abqrc_pkg::KIND_DMA, 1'b1);        // paused DMA: nothing
      send_request(abqrc_pkg::KIND_COMMIT, 1'b1);     // commit ignores hold
      send_request(abqrc_pkg::KIND_DMA, 1'b0);        // recovery: play with fade-in
      send_request(abqrc_pkg::KIND_CAPACITY, 1'b0);   // room left
      repeat (6) send_request(abqrc_pkg::KIND_COMMIT, 1'b0);  // reach start level
      send_request(abqrc_pkg::KIND_RATE, 1'b0);       // filling holds below low release
      send_request(abqrc_pkg::KIND_RESTART + 3'd1, 1'b1);     // unused kinds
      send_request(abqrc_pkg::KIND_RESTART + 3'd2, 1'b0);
      send_request(abqrc_pkg::KIND_RESTART + 3'd3, 1'b1);
      send_request(abqrc_pkg::KIND_CAPACITY, 1'b1);   // pause: stop DMA, clear the ring
      repeat (3) send_request(abqrc_pkg::KIND_COMMIT, 1'b0);
      send_request(abqrc_pkg::KIND_RESTART, 1'b1);    // restart keeps the thresholds
      send_request(abqrc_pkg::KIND_RATE, 1'b1);
      drop_valid();
   endtask

   // Random traffic shaped like a producer and a DMA. The fill bias moves
   // every few dozen requests so the backlog sweeps from starved to wrapped.
   task run_items(int unsigned count);
      int unsigned                  roll;
      int unsigned                  fill_bias;
      logic [abqrc_pkg::KIND_W-1:0] kind;
      logic                         hold;
      fill_bias = 50;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 25 == 0) begin
            case ($urandom_range(0, 3))
               0: fill_bias = 15;
               1: fill_bias = 50;
               2: fill_bias = 80;
               default: fill_bias = 95;
            endcase
         end
         roll = $urandom_range(0, 99);
         hold = 1'($urandom_range(0, 1));
         if (roll < 4) begin
            // restart or unused
            kind = abqrc_pkg::KIND_RESTART + 3'($urandom_range(0, 3));
         end else if (roll < 20) begin
            kind = abqrc_pkg::KIND_RATE;
         end else if (roll < 34) begin
            kind = abqrc_pkg::KIND_CAPACITY;
            hold = ($urandom_range(0, 19) == 0);
         end else if ($urandom_range(0, 99) < fill_bias) begin
            kind = abqrc_pkg::KIND_COMMIT;
         end else begin
            kind = abqrc_pkg::KIND_DMA;
            hold = ($urandom_range(0, 19) == 0);
         end
         send_request(kind, hold);
      end
      drop_valid();
   endtask

   // Sequencer: reset, directed corners, then threshold phases. Thresholds
   // change only once every response is back.
   initial begin
      abqrc_pkg::cfg_type settings;
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();

      for (int phase = 0; phase < 8; phase++) begin
         wait_for_results();
         case (phase)
            0: settings = '0;
            1: settings = {8{5'd16}};
            2: settings = RESET_LIMITS;
            3: settings = WIDE_LIMITS;
            default: begin
               for (int f = 0; f < 8; f++)
                  settings[f*abqrc_pkg::CFG_W +: abqrc_pkg::CFG_W] =
                     abqrc_pkg::CFG_W'($urandom_range(0, 16));
            end
         endcase
         apply_settings(settings);
         // phase 2 runs with no idling at all; phase 3 keeps offering
         // requests back to back while the receiver holds off
         sender_steady   = (phase == 2 || phase == 3);
         receiver_steady = (phase == 2);
         if (phase == 3)
            squeeze_req = 1'b1;
         run_items(PHASE_ITEMS);
      end

      wait_for_results();
      if (board.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: sim.f
src/abqrc_pkg.sv
src/abqrc_csr.sv
src/abqrc_ctrl.sv
src/audio_buffer_queue_rate_control_top.sv
tb/audio_buffer_queue_rate_control_top_tb.sv
